// ===== rtl/seb_pkg.sv =====
// Shared constants, types and state codes for the Sobel inverted edge stream unit.
`default_nettype none

package seb_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int H_W   = $clog2(MAX_HEIGHT + 1);

    localparam int PIX_W        = 8;
    localparam int FRAME_W_BITS = 12;
    localparam int FRAME_H_BITS = 13;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [FRAME_W_BITS-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [FRAME_H_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

    localparam int GRAY_SUM_W = 23;
    localparam int GRAY_SHIFT = 14;
    localparam logic [GRAY_SUM_W-1:0] W_RED   = 23'd4899;
    localparam logic [GRAY_SUM_W-1:0] W_GREEN = 23'd9617;
    localparam logic [GRAY_SUM_W-1:0] W_BLUE  = 23'd1868;
    localparam logic [GRAY_SUM_W-1:0] W_ROUND = 23'd8192;
    localparam logic [PIX_W-1:0]      PIX_MAX = 8'd255;

    localparam int SUM_W  = 10;
    localparam int GRAD_W = 11;
    localparam int RAD_W  = 22;
    localparam int ROOT_W = 11;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_res_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_GRAY   = 6'b000010,
        ST_WIN    = 6'b000100,
        ST_SQUARE = 6'b001000,
        ST_SQRT   = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/sobel_inverted_edge_stream_unit.sv =====
// Top level: BGR pixel stream in, inverted 3x3 Sobel magnitude of interior pixels out.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+-----------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | tdata: blue, green, red; tuser: frame_start
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata: edge_value; tlast: frame_last
//  cfg      | in        | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// One item at a time: a border pixel passes the gray and window steps only; an interior
// pixel also passes square, the 11-step square root and emit, which waits for a free output.
// The two line stores are single-port-read synchronous RAMs, read on accept, written back
// in the window step; no clearing pass after reset.
// rst_n clears counters, window, state and output valid; frame size returns to 640x480.
// A stalled output holds the unit in its final step; no new item or register write enters.
`default_nettype none

module sobel_inverted_edge_stream_unit (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [23:0]                      s_axis_tdata,  // blue[7:0], green[15:8], red[23:16]
    input  wire                              s_axis_tuser,  // frame_start
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // edge_value[7:0]
    output logic                             m_axis_tlast,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [seb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [seb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int COL_W  = seb_pkg::COL_W;
    localparam int ROW_W  = seb_pkg::ROW_W;
    localparam int W_W    = seb_pkg::W_W;
    localparam int H_W    = seb_pkg::H_W;
    localparam int PIX_W  = seb_pkg::PIX_W;
    localparam int FW_B   = seb_pkg::FRAME_W_BITS;
    localparam int FH_B   = seb_pkg::FRAME_H_BITS;
    localparam int GS_W   = seb_pkg::GRAY_SUM_W;
    localparam int SUM_W  = seb_pkg::SUM_W;
    localparam int GRAD_W = seb_pkg::GRAD_W;
    localparam int RAD_W  = seb_pkg::RAD_W;
    localparam int ROOT_W = seb_pkg::ROOT_W;

    seb_pkg::state_t state_reg, state_next;

    logic [FW_B-1:0]  width_reg;
    logic [FH_B-1:0]  height_reg;
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;

    logic [PIX_W-1:0] blue_reg, green_reg, red_reg;
    logic [COL_W-1:0] cur_col_reg;
    logic             emit_reg;
    logic             last_reg;
    logic [PIX_W-1:0] gray_reg;
    logic [PIX_W-1:0] win_reg [6];
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;

    logic             out_valid_reg;
    logic [PIX_W-1:0] out_edge_reg;
    logic             out_last_reg;

    logic [W_W-1:0] w_eff;
    logic [H_W-1:0] h_eff;
    logic [W_W-1:0] col_pre, col_cur, col_inc;
    logic [H_W-1:0] row_pre, row_cur, row_inc;
    logic           accept;
    logic           out_free;

    logic [GS_W-1:0]  gray_sum;
    logic [PIX_W-1:0] gray_val;
    logic [PIX_W-1:0] top_pix, mid_pix;
    logic [SUM_W-1:0] lsum, rsum, tsum, bsum;
    logic signed [2*GRAD_W-1:0] prod_x, prod_y;
    logic [RAD_W-1:0] radicand;
    logic [PIX_W-1:0] edge_val;

    seb_pkg::sqrt_res_t sq_res;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == seb_pkg::ST_IDLE);
    assign cfg_ready     = (state_reg == seb_pkg::ST_IDLE);

    always_comb
    begin
        if (width_reg < FW_B'(seb_pkg::MIN_DIM))
            w_eff = W_W'(seb_pkg::MIN_DIM);
        else if (32'(width_reg) > seb_pkg::MAX_WIDTH)
            w_eff = W_W'(seb_pkg::MAX_WIDTH);
        else
            w_eff = W_W'(width_reg);

        if (height_reg < FH_B'(seb_pkg::MIN_DIM))
            h_eff = H_W'(seb_pkg::MIN_DIM);
        else if (32'(height_reg) > seb_pkg::MAX_HEIGHT)
            h_eff = H_W'(seb_pkg::MAX_HEIGHT);
        else
            h_eff = H_W'(height_reg);
    end

    always_comb
    begin
        col_pre = s_axis_tuser ? '0 : W_W'(col_cnt_reg);
        row_pre = s_axis_tuser ? '0 : H_W'(row_cnt_reg);
        col_cur = col_pre;
        row_cur = row_pre;
        if (col_pre >= w_eff)
        begin
            col_cur = '0;
            row_cur = row_pre + H_W'(1);
        end
        if (row_cur >= h_eff)
        begin
            row_cur = '0;
        end

        col_inc      = col_cur + W_W'(1);
        row_inc      = row_cur + H_W'(1);
        col_cnt_next = col_cur[COL_W-1:0];
        row_cnt_next = row_cur[ROW_W-1:0];
        if (col_inc >= w_eff)
        begin
            col_cnt_next = '0;
            row_cnt_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_cnt_next = col_inc[COL_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            seb_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = seb_pkg::ST_GRAY;
            end
            seb_pkg::ST_GRAY:
                state_next = seb_pkg::ST_WIN;
            seb_pkg::ST_WIN:
                state_next = emit_reg ? seb_pkg::ST_SQUARE : seb_pkg::ST_IDLE;
            seb_pkg::ST_SQUARE:
                state_next = seb_pkg::ST_SQRT;
            seb_pkg::ST_SQRT:
            begin
                if (sq_res.done)
                    state_next = seb_pkg::ST_EMIT;
            end
            seb_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = seb_pkg::ST_IDLE;
            end
            default:
                state_next = seb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        gray_sum = GS_W'(red_reg) * seb_pkg::W_RED + GS_W'(green_reg) * seb_pkg::W_GREEN
                 + GS_W'(blue_reg) * seb_pkg::W_BLUE + seb_pkg::W_ROUND;
        if ((gray_sum >> seb_pkg::GRAY_SHIFT) > GS_W'(seb_pkg::PIX_MAX))
            gray_val = seb_pkg::PIX_MAX;
        else
            gray_val = gray_sum[seb_pkg::GRAY_SHIFT +: PIX_W];
    end

    always_comb
    begin
        lsum = SUM_W'(win_reg[3]) + (SUM_W'(win_reg[4]) << 1) + SUM_W'(win_reg[5]);
        rsum = SUM_W'(top_pix) + (SUM_W'(mid_pix) << 1) + SUM_W'(gray_reg);
        tsum = SUM_W'(win_reg[3]) + (SUM_W'(win_reg[0]) << 1) + SUM_W'(top_pix);
        bsum = SUM_W'(win_reg[5]) + (SUM_W'(win_reg[2]) << 1) + SUM_W'(gray_reg);
    end

    always_comb
    begin
        prod_x   = gx_reg * gx_reg;
        prod_y   = gy_reg * gy_reg;
        radicand = RAD_W'(prod_x) + RAD_W'(prod_y);
        if (sq_res.root >= ROOT_W'(seb_pkg::PIX_MAX))
            edge_val = '0;
        else
            edge_val = PIX_W'(ROOT_W'(seb_pkg::PIX_MAX) - sq_res.root);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= seb_pkg::ST_IDLE;
            width_reg     <= seb_pkg::FRAME_WIDTH_RESET;
            height_reg    <= seb_pkg::FRAME_HEIGHT_RESET;
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == seb_pkg::CFG_FRAME_WIDTH)
                    width_reg <= cfg_data[FW_B-1:0];
                else if (cfg_index == seb_pkg::CFG_FRAME_HEIGHT)
                    height_reg <= cfg_data[FH_B-1:0];
            end
            if (accept)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            if (state_reg == seb_pkg::ST_WIN)
            begin
                win_reg[3] <= win_reg[0];
                win_reg[4] <= win_reg[1];
                win_reg[5] <= win_reg[2];
                win_reg[0] <= top_pix;
                win_reg[1] <= mid_pix;
                win_reg[2] <= gray_reg;
            end
            if (state_reg == seb_pkg::ST_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blue_reg    <= s_axis_tdata[7:0];
            green_reg   <= s_axis_tdata[15:8];
            red_reg     <= s_axis_tdata[23:16];
            cur_col_reg <= col_cur[COL_W-1:0];
            emit_reg    <= (row_cur >= H_W'(2)) && (col_cur >= W_W'(2));
            last_reg    <= (row_cur == h_eff - H_W'(1)) && (col_cur == w_eff - W_W'(1));
        end
        if (state_reg == seb_pkg::ST_GRAY)
        begin
            gray_reg <= gray_val;
        end
        if (state_reg == seb_pkg::ST_WIN)
        begin
            gx_reg <= $signed({1'b0, rsum}) - $signed({1'b0, lsum});
            gy_reg <= $signed({1'b0, bsum}) - $signed({1'b0, tsum});
        end
        if (state_reg == seb_pkg::ST_EMIT && out_free)
        begin
            out_edge_reg <= edge_val;
            out_last_reg <= last_reg;
        end
    end

    seb_line_ram #(
        .DEPTH  (seb_pkg::MAX_WIDTH),
        .DATA_W (PIX_W)
    ) u_line_a (
        .clk   (clk),
        .we    (state_reg == seb_pkg::ST_WIN),
        .waddr (cur_col_reg),
        .wdata (gray_reg),
        .re    (accept),
        .raddr (col_cur[COL_W-1:0]),
        .rdata (mid_pix)
    );

    seb_line_ram #(
        .DEPTH  (seb_pkg::MAX_WIDTH),
        .DATA_W (PIX_W)
    ) u_line_b (
        .clk   (clk),
        .we    (state_reg == seb_pkg::ST_WIN),
        .waddr (cur_col_reg),
        .wdata (mid_pix),
        .re    (accept),
        .raddr (col_cur[COL_W-1:0]),
        .rdata (top_pix)
    );

    seb_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == seb_pkg::ST_SQUARE),
        .radicand (radicand),
        .res      (sq_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_edge_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    a_done_in_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        sq_res.done |-> state_reg == seb_pkg::ST_SQRT)
        else $error("square root finished outside its wait state");

    a_square_interior: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == seb_pkg::ST_SQUARE |-> emit_reg)
        else $error("border pixel entered the magnitude path");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == seb_pkg::ST_GRAY || state_reg == seb_pkg::ST_WIN)
        |-> W_W'(cur_col_reg) < w_eff)
        else $error("line store column beyond frame width");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == seb_pkg::ST_EMIT && m_axis_tvalid && !m_axis_tready
        |=> state_reg == seb_pkg::ST_EMIT && $stable(m_axis_tdata))
        else $error("result overwritten while output stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/seb_line_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module seb_line_ram #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 8
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [DATA_W-1:0]         wdata,
    input  wire                      re,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/seb_isqrt.sv =====
// Iterative ceiling integer square root, one result bit per cycle.
`default_nettype none

module seb_isqrt (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  wire [seb_pkg::RAD_W-1:0] radicand,
    output seb_pkg::sqrt_res_t       res
);

    localparam int RAD_W  = seb_pkg::RAD_W;
    localparam int ROOT_W = seb_pkg::ROOT_W;

    logic [RAD_W-1:0]  x_reg;
    logic [RAD_W-1:0]  acc_reg;
    logic [RAD_W-1:0]  bit_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [RAD_W-1:0]  trial;
    logic              take;
    logic [RAD_W-1:0]  x_next;
    logic [RAD_W-1:0]  acc_next;
    logic [ROOT_W-1:0] root_next;

    always_comb
    begin
        trial     = acc_reg + bit_reg;
        take      = (x_reg >= trial);
        x_next    = take ? (x_reg - trial) : x_reg;
        acc_next  = take ? ((acc_reg >> 1) + bit_reg) : (acc_reg >> 1);
        root_next = acc_next[ROOT_W-1:0] + ROOT_W'(x_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= radicand;
            acc_reg <= '0;
            bit_reg <= RAD_W'(1) << (RAD_W - 2);
        end
        else if (busy_reg)
        begin
            x_reg   <= x_next;
            acc_reg <= acc_next;
            bit_reg <= bit_reg >> 2;
            if (bit_reg[0])
            begin
                root_reg <= root_next;
            end
        end
    end

    assign res.done = done_reg;
    assign res.root = root_reg;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the Sobel inverted edge stream unit: predicts edge results and checks them.
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic [7:0] edge_value;
        logic       frame_last;
    } edge_result_t;

    class sobel_edge_board;
        logic [seb_pkg::FRAME_W_BITS-1:0] frame_width;
        logic [seb_pkg::FRAME_H_BITS-1:0] frame_height;
        logic [7:0]   row_above [seb_pkg::MAX_WIDTH];
        logic [7:0]   row_two_up [seb_pkg::MAX_WIDTH];
        logic [7:0]   window [6];
        int unsigned  col_next;
        int unsigned  row_next;
        edge_result_t pending_edges [$];
        int           mismatch_count;

        function new();
            frame_width  = seb_pkg::FRAME_WIDTH_RESET;
            frame_height = seb_pkg::FRAME_HEIGHT_RESET;
            foreach (row_above[i])
            begin
                row_above[i]  = '0;
                row_two_up[i] = '0;
            end
            foreach (window[i])
                window[i] = '0;
            col_next       = 0;
            row_next       = 0;
            mismatch_count = 0;
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("MISMATCH at %0t: %s", $time, what);
        endtask

        function void write_reg(logic [seb_pkg::CFG_IDX_W-1:0] index,
                                logic [seb_pkg::CFG_DATA_W-1:0] value);
            if (index == seb_pkg::CFG_FRAME_WIDTH)
                frame_width = value[seb_pkg::FRAME_W_BITS-1:0];
            else if (index == seb_pkg::CFG_FRAME_HEIGHT)
                frame_height = value[seb_pkg::FRAME_H_BITS-1:0];
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v < seb_pkg::MIN_DIM)
                return seb_pkg::MIN_DIM;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int unsigned ceil_root(int unsigned v);
            int unsigned root;
            int unsigned trial;
            root = 0;
            for (int b = 11; b >= 0; b--)
            begin
                trial = root | (1 << b);
                if (trial * trial <= v)
                    root = trial;
            end
            if (root * root < v)
                root++;
            return root;
        endfunction

        function void take_pixel(logic [23:0] pixel, logic frame_start);
            int unsigned  w, h, c, r, gray, top, mid, bot, mag;
            int           lsum, rsum, tsum, bsum, gx, gy;
            edge_result_t res;
            w = clamp_dim(frame_width, seb_pkg::MAX_WIDTH);
            h = clamp_dim(frame_height, seb_pkg::MAX_HEIGHT);
            if (frame_start)
            begin
                col_next = 0;
                row_next = 0;
            end
            if (col_next >= w)
            begin
                col_next = 0;
                row_next++;
            end
            if (row_next >= h)
                row_next = 0;
            c = col_next;
            r = row_next;

            gray = (int'(pixel[23:16]) * 4899 + int'(pixel[15:8]) * 9617
                    + int'(pixel[7:0]) * 1868 + 8192) >> 14;
            if (gray > 255)
                gray = 255;

            top = row_two_up[c];
            mid = row_above[c];
            bot = gray;
            row_two_up[c] = 8'(mid);
            row_above[c]  = 8'(bot);

            if (r >= 2 && c >= 2)
            begin
                lsum = int'(window[3]) + 2 * int'(window[4]) + int'(window[5]);
                rsum = int'(top) + 2 * int'(mid) + int'(bot);
                tsum = int'(window[3]) + 2 * int'(window[0]) + int'(top);
                bsum = int'(window[5]) + 2 * int'(window[2]) + int'(bot);
                gx = rsum - lsum;
                gy = bsum - tsum;
                mag = ceil_root(gx * gx + gy * gy);
                res.edge_value = (mag >= 255) ? 8'd0 : 8'(255 - mag);
                res.frame_last = (r == h - 1) && (c == w - 1);
                pending_edges.push_back(res);
            end

            window[3] = window[0];
            window[4] = window[1];
            window[5] = window[2];
            window[0] = 8'(top);
            window[1] = 8'(mid);
            window[2] = 8'(bot);

            col_next = c + 1;
            if (col_next >= w)
            begin
                col_next = 0;
                row_next = r + 1;
                if (row_next >= h)
                    row_next = 0;
            end
        endfunction

        task check_result(logic [7:0] edge_value, logic frame_last);
            edge_result_t want;
            if (pending_edges.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with none pending", edge_value));
                return;
            end
            want = pending_edges.pop_front();
            if (edge_value !== want.edge_value)
                report_mismatch($sformatf("edge_value %0d, want %0d",
                                          edge_value, want.edge_value));
            if (frame_last !== want.frame_last)
                report_mismatch($sformatf("frame_last %0b, want %0b",
                                          frame_last, want.frame_last));
        endtask
    endclass

    logic                              clk           = 1'b0;
    logic                              rst_n         = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [23:0]                       s_axis_tdata  = '0;  // blue[7:0], green[15:8], red[23:16]
    logic                              s_axis_tuser  = 1'b0;  // frame_start
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [7:0]                        m_axis_tdata;  // edge_value[7:0]
    logic                              m_axis_tlast;
    logic                              cfg_valid     = 1'b0;
    logic                              cfg_ready;
    logic [seb_pkg::CFG_IDX_W-1:0]     cfg_index     = '0;
    logic [seb_pkg::CFG_DATA_W-1:0]    cfg_data      = '0;

    sobel_edge_board edges;
    int              idle_pct    = 10;
    int              pixels_sent = 0;

    sobel_inverted_edge_stream_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        m_axis_tready <= (idle_pct == 0) || ($urandom_range(99) >= 10);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            edges.check_result(m_axis_tdata, m_axis_tlast);
    end

    task automatic set_frame_size(input logic [seb_pkg::CFG_DATA_W-1:0] w,
                                  input logic [seb_pkg::CFG_DATA_W-1:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= seb_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        edges.write_reg(seb_pkg::CFG_FRAME_WIDTH, w);
        cfg_index <= seb_pkg::CFG_FRAME_HEIGHT;
        cfg_data  <= h;
        do
            @(posedge clk);
        while (!cfg_ready);
        edges.write_reg(seb_pkg::CFG_FRAME_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] blue, input logic [7:0] green,
                              input logic [7:0] red, input logic frame_start);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1))
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {red, green, blue};
        s_axis_tuser  <= frame_start;
        do
            @(posedge clk);
        while (!s_axis_tready);
        edges.take_pixel({red, green, blue}, frame_start);
        pixels_sent++;
    endtask

    // mode 0: noise, mode 1: smooth ramp, mode 2: flat with rare spikes
    task automatic send_frame(input int cols, input int rows, input int mode,
                              input int stop_after, input logic frame_start);
        int          base;
        int          step_c;
        int          step_r;
        int          lvl;
        int          n;
        logic [23:0] px;
        base   = $urandom_range(255);
        step_c = $urandom_range(40);
        step_r = $urandom_range(40);
        n      = 0;
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < cols; c++)
            begin
                if (n == stop_after)
                    return;
                lvl = base + c * step_c + r * step_r;
                case (mode)
                    0: px = 24'($urandom());
                    1: px = {8'(lvl + $urandom_range(7)), 8'(lvl + $urandom_range(7)),
                             8'(lvl + $urandom_range(7))};
                    default: px = ($urandom_range(9) == 0) ? 24'($urandom()) : {3{8'(base)}};
                endcase
                send_pixel(px[7:0], px[15:8], px[23:16], frame_start && n == 0);
                n++;
            end
        end
    endtask

    // drop valid, drain pending results, then let the pipeline go quiet
    task automatic settle();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (edges.pending_edges.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40)
            @(posedge clk);
        if (edges.pending_edges.size() != 0)
        begin
            edges.report_mismatch($sformatf("%0d results never arrived",
                                            edges.pending_edges.size()));
            edges.pending_edges.delete();
        end
    endtask

    initial
    begin
        #100_000_000;
        $display("sobel_inverted_edge_stream_unit verification failed");
        $finish;
    end

    initial
    begin
        int   w;
        int   h;
        int   cols;
        int   rows;
        int   total;
        int   stop_at;
        int   random_base;
        logic aborted;
        edges = new();
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset frame size: part of the first row of the default width, no results
        send_frame(640, 3, 1, 70, 1'b1);
        settle();

        set_frame_size(13'd3, 13'd3);
        // hard vertical edge: black, gray, white columns
        for (int r = 0; r < 3; r++)
        begin
            send_pixel(8'd0, 8'd0, 8'd0, r == 0);
            send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
            send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        end
        // next frame without frame_start: pure blue, green, red rows
        for (int c = 0; c < 3; c++)
            send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        for (int c = 0; c < 3; c++)
            send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        for (int c = 0; c < 3; c++)
            send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        // restart in the middle of a frame
        send_pixel(8'hAA, 8'h55, 8'hF0, 1'b1);
        send_pixel(8'h0F, 8'hCC, 8'h33, 1'b0);
        for (int n = 0; n < 9; n++)
            send_pixel(8'd100, 8'd100, 8'd100, n == 0);
        settle();

        random_base = pixels_sent;
        while (pixels_sent - random_base < 280)
        begin
            idle_pct = (pixels_sent - random_base >= 100 && pixels_sent - random_base < 200)
                       ? 0 : 10;
            if ($urandom_range(7) == 0)
            begin
                w = $urandom_range(2);
                h = $urandom_range(2);
            end
            else
            begin
                w = $urandom_range(3, 10);
                h = $urandom_range(3, 7);
            end
            set_frame_size(13'(w), 13'(h));
            cols    = (w < 3) ? 3 : w;
            rows    = (h < 3) ? 3 : h;
            total   = cols * rows;
            aborted = 1'b1;
            repeat ($urandom_range(1, 3))
            begin
                stop_at = ($urandom_range(5) == 0) ? $urandom_range(1, total - 1) : total;
                send_frame(cols, rows, $urandom_range(2), stop_at,
                           aborted || ($urandom_range(1) == 1));
                aborted = (stop_at < total);
            end
            settle();
        end
        idle_pct = 10;

        // width register beyond the maximum: start of a wide first row
        set_frame_size(13'd4095, 13'd3);
        send_frame(seb_pkg::MAX_WIDTH, 3, $urandom_range(2), 30, 1'b1);
        settle();

        // height beyond the maximum and width below the minimum: first twelve rows
        set_frame_size(13'd0, 13'd8191);
        send_frame(3, seb_pkg::MAX_HEIGHT, 1, 36, 1'b1);
        settle();

        if (edges.mismatch_count == 0)
            $display("sobel_inverted_edge_stream_unit verification clean");
        else
            $display("sobel_inverted_edge_stream_unit verification failed");
        $finish;
    end

endmodule
